[src/ptc_pkg.sv]
// Shared constants, calibration record type and register indexes for the
// pressure / temperature compensation pipeline. No dependencies.
package ptc_pkg;

  localparam int RawW    = 20;   // raw converter reading
  localparam int TempW   = 16;   // compensated temperature
  localparam int PressW  = 32;   // compensated pressure, Q24.8
  localparam int FineW   = 26;   // fine temperature, with headroom
  localparam int CalW    = 48;   // one calibration register
  localparam int CfgIdxW = 2;
  localparam int WordW   = 64;   // pressure datapath word
  localparam int DenW    = 31;   // pressure divisor after the 33-bit shift

  localparam int TempGain   = 5;
  localparam int TempRound  = 128;
  localparam int TempMax    = 32767;
  localparam int TempMin    = -32768;
  localparam int FineOffset = 128000;
  localparam int PressBase  = 1048576;
  localparam int PressScale = 3125;

  localparam int TempStages = 4;
  localparam int PreStages  = 6;
  localparam int DivStages  = WordW + 2;
  localparam int PostStages = 5;
  localparam int Latency    = TempStages + PreStages + DivStages + PostStages;

  typedef logic [CfgIdxW-1:0] reg_idx_t;

  localparam reg_idx_t REG_TEMP    = reg_idx_t'(0);
  localparam reg_idx_t REG_PRESS_A = reg_idx_t'(1);
  localparam reg_idx_t REG_PRESS_B = reg_idx_t'(2);
  localparam reg_idx_t REG_PRESS_C = reg_idx_t'(3);

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

endpackage

[src/ptc_temp.sv]
// Temperature stages: fine temperature and saturated centi-degree result.
// Four register stages. Depends on ptc_pkg.
module ptc_temp #(
  parameter int TagW = ptc_pkg::RawW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [ptc_pkg::RawW-1:0]          adc_t,
  input  ptc_pkg::cal_t                     cal,
  input  logic [TagW-1:0]                   tag_in,
  output logic                              out_valid,
  output logic signed [ptc_pkg::FineW-1:0]  fine,
  output logic signed [ptc_pkg::TempW-1:0]  temp_centi,
  output logic [TagW-1:0]                   tag_out
);

  localparam int RW = ptc_pkg::RawW;
  localparam int FW = ptc_pkg::FineW;
  localparam int TW = ptc_pkg::TempW;

  logic [3:0]              valid;
  logic [TagW-1:0]         tag1, tag2, tag3, tag4;
  logic signed [17:0]      d1;
  logic signed [16:0]      d2;
  logic signed [33:0]      m1, sq;
  logic signed [22:0]      v1t;
  logic signed [37:0]      m2;
  logic signed [23:0]      v2t;
  logic signed [FW-1:0]    fine_next;
  logic signed [28:0]      tx;
  logic signed [20:0]      tq;
  logic signed [TW-1:0]    tc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d1   <= $signed({1'b0, adc_t[RW-1:3]}) - $signed({1'b0, cal.t1, 1'b0});
    d2   <= $signed({1'b0, adc_t[RW-1:4]}) - $signed({1'b0, cal.t1});
    tag1 <= tag_in;
    m1   <= 34'(d1) * 34'(cal.t2);
    sq   <= 34'(d2) * 34'(d2);
    tag2 <= tag1;
    // square is never negative, so its top bit is clear
    v1t  <= m1[33:11];
    m2   <= 38'($signed(sq[33:12])) * 38'(cal.t3);
    tag3 <= tag2;
    fine       <= fine_next;
    temp_centi <= tc_next;
    tag4       <= tag3;
  end

  always_comb begin
    v2t       = m2[37:14];
    fine_next = FW'(v1t) + FW'(v2t);
    tx        = 29'(fine_next) * 29'(ptc_pkg::TempGain) + 29'(ptc_pkg::TempRound);
    tq        = tx[28:8];
    if (tq > 21'(ptc_pkg::TempMax)) begin
      tc_next = TW'(ptc_pkg::TempMax);
    end else if (tq < 21'(ptc_pkg::TempMin)) begin
      tc_next = TW'(ptc_pkg::TempMin);
    end else begin
      tc_next = tq[TW-1:0];
    end
  end

  assign out_valid = valid[3];
  assign tag_out   = tag4;

endmodule

[src/ptc_press_pre.sv]
// Pressure front stages: divisor and scaled numerator from the fine
// temperature. Six register stages, all sums modulo 2^64. Depends on ptc_pkg.
module ptc_press_pre #(
  parameter int TagW = ptc_pkg::TempW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [ptc_pkg::FineW-1:0]  fine,
  input  logic [ptc_pkg::RawW-1:0]          adc_p,
  input  ptc_pkg::cal_t                     cal,
  input  logic [TagW-1:0]                   tag_in,
  output logic                              out_valid,
  output logic [ptc_pkg::WordW-1:0]         num,
  output logic signed [ptc_pkg::DenW-1:0]   den,
  output logic [TagW-1:0]                   tag_out
);

  localparam int W      = ptc_pkg::WordW;
  localparam int DW     = ptc_pkg::DenW;
  localparam int Stages = ptc_pkg::PreStages;

  logic [Stages-1:0]   valid;
  logic [TagW-1:0]     tag_q [Stages];
  logic signed [26:0]  pv1;
  logic [20:0]         pp1, pp2, pp3, pp4;
  logic signed [53:0]  sq;
  logic signed [42:0]  m5, m2, m5_3, m2_3;
  logic [W-1:0]        a6, a3, v2, v1, d, nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_q[0] <= tag_in;
    for (int k = 1; k < Stages; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    pv1  <= 27'(fine) - 27'(ptc_pkg::FineOffset);
    pp1  <= 21'(ptc_pkg::PressBase) - 21'(adc_p);
    sq   <= 54'(pv1) * 54'(pv1);
    m5   <= 43'(pv1) * 43'(cal.p5);
    m2   <= 43'(pv1) * 43'(cal.p2);
    pp2  <= pp1;
    a6   <= W'(sq) * W'(cal.p6);
    a3   <= W'(sq) * W'(cal.p3);
    m5_3 <= m5;
    m2_3 <= m2;
    pp3  <= pp2;
    v2   <= a6 + (W'(m5_3) << 17) + (W'(cal.p4) << 35);
    v1   <= W'($signed(a3) >>> 8) + (W'(m2_3) << 12) + (W'(1) << 47);
    pp4  <= pp3;
    d    <= v1 * W'(cal.p1);
    nb   <= (W'(pp4) << 31) - v2;
    // arithmetic shift by 33 leaves a 31-bit signed divisor
    den  <= d[W-1:W-DW];
    num  <= nb * W'(ptc_pkg::PressScale);
  end

  assign out_valid = valid[Stages-1];
  assign tag_out   = tag_q[Stages-1];

endmodule

[src/ptc_div.sv]
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Sign stage, 64 restoring steps, negate stage. Depends on ptc_pkg.
module ptc_div #(
  parameter int TagW = ptc_pkg::TempW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [ptc_pkg::WordW-1:0]         num,
  input  logic signed [ptc_pkg::DenW-1:0]   den,
  input  logic [TagW-1:0]                   tag_in,
  output logic                              out_valid,
  output logic [ptc_pkg::WordW-1:0]         quo,
  output logic                              zero,
  output logic [TagW-1:0]                   tag_out
);

  localparam int W     = ptc_pkg::WordW;
  localparam int DW    = ptc_pkg::DenW;
  localparam int Steps = W;

  logic [Steps:0]   vld;
  logic [DW-1:0]    rem_q  [Steps];
  logic [DW-1:0]    ud_q   [Steps];
  logic [W-1:0]     dv_q   [Steps+1];
  logic             neg_q  [Steps+1];
  logic             zero_q [Steps+1];
  logic [TagW-1:0]  tag_q  [Steps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[Steps-1:0], in_valid};
      out_valid <= vld[Steps];
    end
  end

  // take magnitudes; the most negative numerator stays 2^63 as unsigned
  always_ff @(posedge clk) begin
    dv_q[0]   <= num[W-1] ? (~num + W'(1)) : num;
    ud_q[0]   <= $unsigned(den[DW-1] ? -den : den);
    rem_q[0]  <= '0;
    neg_q[0]  <= num[W-1] ^ den[DW-1];
    zero_q[0] <= (den == '0);
    tag_q[0]  <= tag_in;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    always_comb begin
      trial = {rem_q[k], dv_q[k][W-1]};
      diff  = trial - {1'b0, ud_q[k]};
      take  = (trial >= {1'b0, ud_q[k]});
    end

    always_ff @(posedge clk) begin
      dv_q[k+1]   <= {dv_q[k][W-2:0], take};
      neg_q[k+1]  <= neg_q[k];
      zero_q[k+1] <= zero_q[k];
      tag_q[k+1]  <= tag_q[k];
    end

    if (k < Steps - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_q[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        ud_q[k+1]  <= ud_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    quo     <= neg_q[Steps] ? (~dv_q[Steps] + W'(1)) : dv_q[Steps];
    zero    <= zero_q[Steps];
    tag_out <= tag_q[Steps];
  end

endmodule

[src/ptc_press_post.sv]
// Pressure back stages: second-order correction on the quotient, offset and
// Q24.8 result; zero divisor forces 0. Five register stages. Depends on ptc_pkg.
module ptc_press_post #(
  parameter int TagW = ptc_pkg::TempW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [ptc_pkg::WordW-1:0]         quo,
  input  logic                              zero_in,
  input  ptc_pkg::cal_t                     cal,
  input  logic [TagW-1:0]                   tag_in,
  output logic                              out_valid,
  output logic [ptc_pkg::PressW-1:0]        pressure,
  output logic                              zero,
  output logic [TagW-1:0]                   tag_out
);

  localparam int W  = ptc_pkg::WordW;
  localparam int HW = W / 2;
  localparam int PW = ptc_pkg::PressW;

  logic [3:0]             valid;
  logic [TagW-1:0]        tag_q [4];
  logic [3:0]             z_q;
  logic [W-1:0]           sh, a1, sh1, w2p, pp0, prod;
  logic [HW-1:0]          pp1, pp2;
  logic [39:0]            q1, q2, q3, w2_2, w2_3, w1, s;
  logic [PW-1:0]          sm;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      valid     <= {valid[2:0], in_valid};
      out_valid <= valid[3];
    end
  end

  assign sh = W'($signed(quo) >>> 13);

  always_ff @(posedge clk) begin
    tag_q[0] <= tag_in;
    z_q[0]   <= zero_in;
    for (int k = 1; k < 4; k++) begin
      tag_q[k] <= tag_q[k-1];
      z_q[k]   <= z_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    // 64 x 16 products, low word kept
    a1   <= sh * W'(cal.p9);
    w2p  <= quo * W'(cal.p8);
    sh1  <= sh;
    q1   <= quo[39:0];
    // low word of a1 * sh1 from three 32 x 32 partial products
    pp0  <= W'(a1[HW-1:0]) * W'(sh1[HW-1:0]);
    pp1  <= a1[HW-1:0] * sh1[W-1:HW];
    pp2  <= a1[W-1:HW] * sh1[HW-1:0];
    w2_2 <= w2p[58:19];
    q2   <= q1;
    prod <= pp0 + {pp1 + pp2, HW'(0)};
    w2_3 <= w2_2;
    q3   <= q2;
    sm   <= s[39:8];
    pressure <= z_q[3] ? '0 : sm + {{12{cal.p7[15]}}, cal.p7, 4'b0};
    zero     <= z_q[3];
    tag_out  <= tag_q[3];
  end

  // only bits 39:8 of the sum reach the result
  always_comb begin
    w1 = {prod[W-1], prod[W-1:25]};
    s  = q3 + w1 + w2_3;
  end

endmodule

[src/pressure_temperature_compensation_unit.sv]
// Channel   Ports                                         Transfer
// input     start, busy, raw_pressure, raw_temperature    start && !busy
// result    done, temperature_centi, pressure_q24_8,      done (one cycle)
//           divisor_zero
// config    cfg_write, cfg_index, cfg_data                cfg_write
//
// One reading per cycle while busy is low; each result passes through the 64
// one-bit steps of the divider plus 17 other datapath stages.
// Synchronous reset clears the calibration registers and all stage valids.
// busy is high only during reset. Results are never held back.
module pressure_temperature_compensation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ptc_pkg::RawW-1:0]          raw_pressure,
  input  logic [ptc_pkg::RawW-1:0]          raw_temperature,
  input  logic                              cfg_write,
  input  ptc_pkg::reg_idx_t                 cfg_index,
  input  logic [ptc_pkg::CalW-1:0]          cfg_data,
  output logic                              done,
  output logic signed [ptc_pkg::TempW-1:0]  temperature_centi,
  output logic [ptc_pkg::PressW-1:0]        pressure_q24_8,
  output logic                              divisor_zero
);

  localparam int TW = ptc_pkg::TempW;

  logic [ptc_pkg::CalW-1:0]          temp_cal, press_cal_a, press_cal_b, press_cal_c;
  ptc_pkg::cal_t                     cal;
  logic                              in_valid;
  logic                              t_valid, p_valid, d_valid;
  logic signed [ptc_pkg::FineW-1:0]  fine;
  logic signed [TW-1:0]              t_centi;
  logic [ptc_pkg::RawW-1:0]          t_adc_p;
  logic [ptc_pkg::WordW-1:0]         num, quo;
  logic signed [ptc_pkg::DenW-1:0]   den;
  logic [TW-1:0]                     p_tag, d_tag, o_tag;
  logic                              d_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ptc_pkg::REG_TEMP:    temp_cal    <= cfg_data;
        ptc_pkg::REG_PRESS_A: press_cal_a <= cfg_data;
        ptc_pkg::REG_PRESS_B: press_cal_b <= cfg_data;
        ptc_pkg::REG_PRESS_C: press_cal_c <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal[15:0];
    cal.t2 = temp_cal[31:16];
    cal.t3 = temp_cal[47:32];
    cal.p1 = press_cal_a[15:0];
    cal.p2 = press_cal_a[31:16];
    cal.p3 = press_cal_a[47:32];
    cal.p4 = press_cal_b[15:0];
    cal.p5 = press_cal_b[31:16];
    cal.p6 = press_cal_b[47:32];
    cal.p7 = press_cal_c[15:0];
    cal.p8 = press_cal_c[31:16];
    cal.p9 = press_cal_c[47:32];
  end

  assign busy     = rst;
  assign in_valid = start && !busy;

  ptc_temp #(.TagW(ptc_pkg::RawW)) u_temp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .adc_t      (raw_temperature),
    .cal        (cal),
    .tag_in     (raw_pressure),
    .out_valid  (t_valid),
    .fine       (fine),
    .temp_centi (t_centi),
    .tag_out    (t_adc_p)
  );

  ptc_press_pre #(.TagW(TW)) u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .fine      (fine),
    .adc_p     (t_adc_p),
    .cal       (cal),
    .tag_in    (t_centi),
    .out_valid (p_valid),
    .num       (num),
    .den       (den),
    .tag_out   (p_tag)
  );

  ptc_div #(.TagW(TW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .num       (num),
    .den       (den),
    .tag_in    (p_tag),
    .out_valid (d_valid),
    .quo       (quo),
    .zero      (d_zero),
    .tag_out   (d_tag)
  );

  ptc_press_post #(.TagW(TW)) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .quo       (quo),
    .zero_in   (d_zero),
    .cal       (cal),
    .tag_in    (d_tag),
    .out_valid (done),
    .pressure  (pressure_q24_8),
    .zero      (divisor_zero),
    .tag_out   (o_tag)
  );

  assign temperature_centi = o_tag;

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(ptc_pkg::Latency) done)
    else $error("result missing at fixed latency");

  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    done && divisor_zero |-> pressure_q24_8 == '0)
    else $error("pressure not forced to zero");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule
